// ===== src/crp_pkg.sv =====
package crp_pkg;

  localparam int unsigned FRAMES_DEF    = 16;
  localparam int unsigned PAGE_BITS_DEF = 20;
  localparam int unsigned SLOT_W        = 4;

  // Value written into a referenced bit when a page is inserted or touched.
  localparam logic PTE_A = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_REFERENCE = 2'd1,
    OP_EVICT     = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic valid;
    op_e  op;
  } cmd_t;

endpackage

// ===== src/crp_front.sv =====
module crp_front import crp_pkg::*; #(
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           opcode_i,
  input  logic [PAGE_BITS-1:0] page_number_i,
  output logic                 busy_o,
  input  logic                 pop_i,
  output cmd_t                 cmd_o,
  output logic [PAGE_BITS-1:0] page_o
);

  op_e                 op_dec;
  op_e                 op_mem [2];
  logic [PAGE_BITS-1:0] page_mem [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          count_q, count_d;
  logic                push;
  logic                pop;

  always_comb begin
    case (opcode_i)
      OP_INSERT:    op_dec = OP_INSERT;
      OP_REFERENCE: op_dec = OP_REFERENCE;
      OP_EVICT:     op_dec = OP_EVICT;
      default:      op_dec = OP_NONE;
    endcase
  end

  assign busy_o = (count_q == 2'd2);
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_mem[wr_ptr_q]   <= op_dec;
      page_mem[wr_ptr_q] <= page_number_i;
    end
  end

  assign cmd_o.valid = (count_q != 2'd0);
  assign cmd_o.op    = op_mem[rd_ptr_q];
  assign page_o      = page_mem[rd_ptr_q];

endmodule

// ===== src/crp_back.sv =====
module crp_back import crp_pkg::*; #(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [PAGE_BITS-1:0] page_i,
  output logic                 pop_o,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic [PAGE_BITS-1:0] victim_page_o
);

  localparam int unsigned SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);
  localparam logic [SW-1:0] LAST = SW'(FRAMES - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REF    = 3'd1;
  localparam logic [2:0] S_EVSCAN = 3'd2;
  localparam logic [2:0] S_EVRD   = 3'd3;
  localparam logic [2:0] S_EVOUT  = 3'd4;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    next_slot = (s == LAST) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SW-1:0] prev_slot(input logic [SW-1:0] s);
    prev_slot = (s == '0) ? LAST : s - 1'b1;
  endfunction

  logic [2:0]           state_q, state_d;
  logic [FRAMES-1:0]    valid_q, valid_d;
  logic [FRAMES-1:0]    ref_q, ref_d;
  logic [SW-1:0]        hand_q, hand_d;
  logic [CW-1:0]        fill_count_q, fill_count_d;
  logic                 filling_q, filling_d;
  logic [PAGE_BITS-1:0] page_q, page_d;

  logic [SW-1:0]        idx_q, idx_d;
  logic [SW-1:0]        cnt_q, cnt_d;
  logic                 any_q, any_d;
  logic [SW-1:0]        first_q, first_d;
  logic [SW-1:0]        victim_q, victim_d;
  logic                 issuing_q, issuing_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic                 cmp_last_q, cmp_last_d;
  logic [SW-1:0]        cmp_idx_q, cmp_idx_d;

  logic                 done_q, done_d;
  logic [1:0]           status_q, status_d;
  logic [SW-1:0]        slot_q, slot_d;
  logic [PAGE_BITS-1:0] victim_page_q, victim_page_d;

  logic [PAGE_BITS-1:0] page_mem [FRAMES];
  logic [PAGE_BITS-1:0] mem_q;
  logic                 mem_we;
  logic [SW-1:0]        wr_addr;
  logic [SW-1:0]        rd_addr;

  logic [SW-1:0]        ins_at;
  logic                 ins_full;
  logic                 scan_v;
  logic                 scan_r;
  logic                 any_n;
  logic [SW-1:0]        first_n;
  logic [SW+SLOT_W-1:0] slot_ext;

  assign ins_at   = filling_q ? fill_count_q[SW-1:0] : prev_slot(hand_q);
  assign ins_full = filling_q ? (fill_count_q == CW'(FRAMES)) : valid_q[ins_at];

  assign scan_v  = valid_q[idx_q];
  assign scan_r  = ref_q[idx_q];
  assign any_n   = any_q || scan_v;
  assign first_n = (scan_v && !any_q) ? idx_q : first_q;

  assign rd_addr = (state_q == S_REF) ? idx_q : victim_q;
  assign wr_addr = ins_at;

  always_comb begin
    state_d       = state_q;
    valid_d       = valid_q;
    ref_d         = ref_q;
    hand_d        = hand_q;
    fill_count_d  = fill_count_q;
    filling_d     = filling_q;
    page_d        = page_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    any_d         = any_q;
    first_d       = first_q;
    victim_d      = victim_q;
    issuing_d     = issuing_q;
    cmp_vld_d     = 1'b0;
    cmp_last_d    = 1'b0;
    cmp_idx_d     = idx_q;
    done_d        = 1'b0;
    status_d      = ST_OK;
    slot_d        = '0;
    victim_page_d = '0;
    mem_we        = 1'b0;
    pop_o         = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          pop_o  = 1'b1;
          page_d = page_i;
          case (cmd_i.op)
            OP_INSERT: begin
              done_d = 1'b1;
              if (ins_full) begin
                status_d = ST_FULL;
              end else begin
                mem_we          = 1'b1;
                valid_d[ins_at] = 1'b1;
                ref_d[ins_at]   = PTE_A;
                slot_d          = ins_at;
                if (filling_q) begin
                  fill_count_d = fill_count_q + 1'b1;
                end
              end
            end
            OP_REFERENCE: begin
              state_d    = S_REF;
              idx_d      = '0;
              issuing_d  = 1'b1;
            end
            OP_EVICT: begin
              state_d = S_EVSCAN;
              idx_d   = hand_q;
              cnt_d   = '0;
              any_d   = 1'b0;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_REF: begin
        // Reads are issued one slot ahead of the compare on the registered data.
        cmp_vld_d  = issuing_q && valid_q[idx_q];
        cmp_last_d = issuing_q && (idx_q == LAST);
        cmp_idx_d  = idx_q;
        if (issuing_q) begin
          if (idx_q == LAST) begin
            issuing_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (cmp_vld_q && (mem_q == page_q)) begin
          ref_d[cmp_idx_q] = PTE_A;
          done_d           = 1'b1;
          slot_d           = cmp_idx_q;
          state_d          = S_IDLE;
        end else if (cmp_last_q) begin
          done_d   = 1'b1;
          status_d = ST_MISSING;
          state_d  = S_IDLE;
        end
      end
      S_EVSCAN: begin
        any_d   = any_n;
        first_d = first_n;
        if (scan_v && !scan_r) begin
          victim_d = idx_q;
          state_d  = S_EVRD;
        end else begin
          if (scan_v) begin
            ref_d[idx_q] = 1'b0;
          end
          if (cnt_q == LAST) begin
            // A full turn without a clear bit falls back to the first valid slot.
            if (!any_n) begin
              done_d   = 1'b1;
              status_d = ST_EMPTY;
              state_d  = S_IDLE;
            end else begin
              victim_d = first_n;
              state_d  = S_EVRD;
            end
          end else begin
            idx_d = next_slot(idx_q);
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_EVRD: begin
        state_d = S_EVOUT;
      end
      S_EVOUT: begin
        valid_d[victim_q] = 1'b0;
        ref_d[victim_q]   = 1'b0;
        hand_d            = next_slot(victim_q);
        filling_d         = 1'b0;
        done_d            = 1'b1;
        slot_d            = victim_q;
        victim_page_d     = mem_q;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      ref_q        <= '0;
      hand_q       <= '0;
      fill_count_q <= '0;
      filling_q    <= 1'b1;
      idx_q        <= '0;
      cnt_q        <= '0;
      any_q        <= 1'b0;
      first_q      <= '0;
      victim_q     <= '0;
      issuing_q    <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_last_q   <= 1'b0;
      cmp_idx_q    <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      ref_q        <= ref_d;
      hand_q       <= hand_d;
      fill_count_q <= fill_count_d;
      filling_q    <= filling_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      any_q        <= any_d;
      first_q      <= first_d;
      victim_q     <= victim_d;
      issuing_q    <= issuing_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_last_q   <= cmp_last_d;
      cmp_idx_q    <= cmp_idx_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q        <= page_d;
    status_q      <= status_d;
    slot_q        <= slot_d;
    victim_page_q <= victim_page_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      page_mem[wr_addr] <= page_i;
    end
    mem_q <= page_mem[rd_addr];
  end

  assign slot_ext      = {{SLOT_W{1'b0}}, slot_q};
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign slot_o        = slot_ext[SLOT_W-1:0];
  assign victim_page_o = victim_page_q;

  // While the ring first fills, the number of valid slots equals the fill count.
  a_fill_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filling_q |-> ($countones(valid_q) == int'(fill_count_q)))
    else $error("valid slots disagree with the fill count");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_count_q) <= FRAMES)
    else $error("fill count beyond the ring size");

  a_filling_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !filling_q |=> !filling_q)
    else $error("filling set again after an eviction");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q != ST_OK)) |-> ((slot_q == '0) && (victim_page_q == '0)))
    else $error("error result carries a slot or a page");

  a_one_result_per_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe while a command is still in progress");

endmodule

// ===== src/clock_page_replacement.sv =====
// Clock (second-chance) page replacement over a ring of FRAMES slots. A command
// is taken when start_i is high and busy_o is low; a two-entry queue holds
// commands while the engine works, so busy_o rises only when that queue is full.
// Each command gives exactly one result, shown for a single cycle with done_o;
// the receiver cannot stall it and must take it in that cycle. After leaving
// the queue, insert and unused opcodes finish in the engine cycle that takes
// the command; reference takes the command, then sweeps the page memory
// sequentially, one read per cycle, comparing each registered read with the
// page; evict takes the command, scans up to FRAMES slots from the hand, one
// slot of the hand scan per cycle, then does one page memory read and the
// write-back. The result appears on the cycle after the engine finishes.
module clock_page_replacement import crp_pkg::*; #(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           opcode_i,
  input  logic [PAGE_BITS-1:0] page_number_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic [PAGE_BITS-1:0] victim_page_o
);

  cmd_t                 cmd;
  logic [PAGE_BITS-1:0] cmd_page;
  logic                 pop;

  crp_front #(
    .PAGE_BITS(PAGE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .opcode_i      (opcode_i),
    .page_number_i (page_number_i),
    .busy_o        (busy_o),
    .pop_i         (pop),
    .cmd_o         (cmd),
    .page_o        (cmd_page)
  );

  crp_back #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .page_i        (cmd_page),
    .pop_o         (pop),
    .done_o        (done_o),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .victim_page_o (victim_page_o)
  );

endmodule
